### design/dsh4_pkg.sv
`default_nettype none

package dsh4_pkg;

  localparam int unsigned FRAME_BITS       = 16;
  localparam int unsigned BIT_IDX_W        = $clog2(FRAME_BITS);
  localparam int unsigned TELEM_SHIFT      = 5;
  localparam int unsigned THR_W            = 11;
  localparam int unsigned MAX_CHANNELS     = 4;
  localparam int unsigned CHANNELS_DEFAULT = 4;
  localparam int unsigned LEVELS_W         = 4;
  localparam int unsigned INTERVAL_W       = 16;
  localparam int unsigned TICK_W           = 8;
  localparam int unsigned CANCEL_W         = 32;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 16;

  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = 16'd125;
  localparam logic [TICK_W-1:0]     BIT_PERIOD_RST   = 8'd139;
  localparam logic [TICK_W-1:0]     ZERO_HIGH_RST    = 8'd50;
  localparam logic [TICK_W-1:0]     ONE_HIGH_RST     = 8'd100;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SEND = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_INTERVAL = 2'd0,
    CFG_BIT_PERIOD   = 2'd1,
    CFG_ZERO_HIGH    = 2'd2,
    CFG_ONE_HIGH     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [LEVELS_W-1:0] line_levels;
    logic                busy_res;
    logic                accepted;
    logic                rejected;
    logic [CANCEL_W-1:0] cancel_total;
  } out_word_t;

  // Throttle in the upper eleven bits, telemetry bit low, checksum nibble at the bottom.
  function automatic logic [FRAME_BITS-1:0] build_frame(input logic [THR_W-1:0] thr);
    logic [FRAME_BITS-1:0] data;
    logic [3:0]            sum;
    data = {thr, {TELEM_SHIFT{1'b0}}};
    sum  = data[15:12] ^ data[11:8] ^ data[7:4];
    return {data[15:4], sum};
  endfunction

endpackage

`default_nettype wire

### design/dsh4_if.sv
`default_nettype none

interface dsh4_in_if;
  import dsh4_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [THR_W-1:0] throttle_a;
  logic [THR_W-1:0] throttle_b;
  logic [THR_W-1:0] throttle_c;
  logic [THR_W-1:0] throttle_d;

  modport source (output valid, opcode, throttle_a, throttle_b, throttle_c, throttle_d,
                  input ready);
  modport sink   (input valid, opcode, throttle_a, throttle_b, throttle_c, throttle_d,
                  output ready);
endinterface

interface dsh4_out_if;
  import dsh4_pkg::*;

  logic                valid;
  logic                ready;
  logic [LEVELS_W-1:0] line_levels;
  logic                busy_res;
  logic                accepted;
  logic                rejected;
  logic [CANCEL_W-1:0] cancel_total;

  modport source (output valid, line_levels, busy_res, accepted, rejected, cancel_total,
                  input ready);
  modport sink   (input valid, line_levels, busy_res, accepted, rejected, cancel_total,
                  output ready);
endinterface

`default_nettype wire

### design/dshot_four_channel_transmitter.sv
// Results are registered: result register, or skid register while the output stalls.
// Throughput: one input word per cycle while the skid register is empty; state and
// rate limit update in a single pass. A two-entry output stage (result register plus
// skid register) keeps input flowing for one more word while the output is stalled.
// Reset (synchronous, rst_n low): config registers return to their defaults, line idle,
// counters cleared, both output entries empty.
`default_nettype none

module dshot_four_channel_transmitter #(
  parameter int unsigned CHANNELS = dsh4_pkg::CHANNELS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [dsh4_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [dsh4_pkg::CFG_DATA_W-1:0] cfg_data,
  dsh4_in_if.sink                             in_ch,
  dsh4_out_if.source                          out_ch
);
  import dsh4_pkg::*;

  localparam int unsigned ACT = (CHANNELS < MAX_CHANNELS) ? CHANNELS : MAX_CHANNELS;

  logic [INTERVAL_W-1:0] min_interval_r;
  logic [TICK_W-1:0]     bit_period_r;
  logic [TICK_W-1:0]     zero_high_r;
  logic [TICK_W-1:0]     one_high_r;

  logic [INTERVAL_W-1:0] ticks_r, ticks_nxt;
  logic [FRAME_BITS-1:0] frame_r   [ACT];
  logic [FRAME_BITS-1:0] frame_nxt [ACT];
  logic [BIT_IDX_W-1:0]  bit_r, bit_nxt;
  logic [TICK_W-1:0]     phase_r, phase_nxt;
  logic                  sending_r, sending_nxt;
  logic [CANCEL_W-1:0]   cancel_r, cancel_nxt;

  out_word_t out_r, skid_r, res;
  logic      out_v_r, skid_v_r;

  logic                  in_acc, out_fire, is_send, acc, rej;
  logic [THR_W-1:0]      thr [MAX_CHANNELS];
  logic [FRAME_BITS-1:0] new_frame [ACT];
  logic [FRAME_BITS-1:0] v_frame;
  logic [BIT_IDX_W-1:0]  v_bit;
  logic [TICK_W-1:0]     v_phase, hi;
  logic                  v_send;
  logic [LEVELS_W-1:0]   lv;

  assign in_ch.ready = !skid_v_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_fire    = out_v_r && out_ch.ready;

  assign thr[0] = in_ch.throttle_a;
  assign thr[1] = in_ch.throttle_b;
  assign thr[2] = in_ch.throttle_c;
  assign thr[3] = in_ch.throttle_d;

  assign is_send = (in_ch.opcode == OP_SEND);
  assign acc     = is_send && (ticks_r >= min_interval_r);
  assign rej     = is_send && !acc;

  always_comb begin
    for (int n = 0; n < ACT; n++) begin
      new_frame[n] = build_frame(thr[n]);
    end
  end

  // Levels show the current tick, or the first phase of a freshly accepted frame.
  always_comb begin
    v_bit   = acc ? '0 : bit_r;
    v_phase = acc ? '0 : phase_r;
    v_send  = acc || sending_r;
    lv      = '0;
    for (int n = 0; n < ACT; n++) begin
      v_frame = acc ? new_frame[n] : frame_r[n];
      hi      = v_frame[BIT_IDX_W'(FRAME_BITS - 1) - v_bit] ? one_high_r : zero_high_r;
      lv[n]   = v_send && (v_phase < hi);
    end
  end

  always_comb begin
    res.line_levels  = lv;
    res.busy_res     = v_send;
    res.accepted     = acc;
    res.rejected     = rej;
    res.cancel_total = cancel_nxt;
  end

  always_comb begin
    ticks_nxt   = ticks_r;
    bit_nxt     = bit_r;
    phase_nxt   = phase_r;
    sending_nxt = sending_r;
    cancel_nxt  = cancel_r;
    for (int n = 0; n < ACT; n++) begin
      frame_nxt[n] = frame_r[n];
    end
    if (!is_send) begin
      if (ticks_r != '1) begin
        ticks_nxt = ticks_r + 1'b1;
      end
      if (sending_r) begin
        if ({1'b0, phase_r} + 1'b1 >= {1'b0, bit_period_r}) begin
          phase_nxt = '0;
          if (bit_r == BIT_IDX_W'(FRAME_BITS - 1)) begin
            bit_nxt     = '0;
            sending_nxt = 1'b0;
          end else begin
            bit_nxt = bit_r + 1'b1;
          end
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
      end
    end else if (acc) begin
      ticks_nxt   = '0;
      bit_nxt     = '0;
      phase_nxt   = '0;
      sending_nxt = 1'b1;
      for (int n = 0; n < ACT; n++) begin
        frame_nxt[n] = new_frame[n];
      end
    end else if (cancel_r != '1) begin
      cancel_nxt = cancel_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r <= MIN_INTERVAL_RST;
      bit_period_r   <= BIT_PERIOD_RST;
      zero_high_r    <= ZERO_HIGH_RST;
      one_high_r     <= ONE_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_INTERVAL: min_interval_r <= cfg_data;
        CFG_BIT_PERIOD:   bit_period_r   <= cfg_data[TICK_W-1:0];
        CFG_ZERO_HIGH:    zero_high_r    <= cfg_data[TICK_W-1:0];
        CFG_ONE_HIGH:     one_high_r     <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r   <= '0;
      bit_r     <= '0;
      phase_r   <= '0;
      sending_r <= 1'b0;
      cancel_r  <= '0;
    end else if (in_acc) begin
      ticks_r   <= ticks_nxt;
      bit_r     <= bit_nxt;
      phase_r   <= phase_nxt;
      sending_r <= sending_nxt;
      cancel_r  <= cancel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int n = 0; n < ACT; n++) begin
        frame_r[n] <= frame_nxt[n];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_fire) begin
      if (skid_v_r) begin
        out_r    <= skid_r;
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_r   <= res;
        out_v_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_r   <= res;
      skid_v_r <= 1'b1;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.line_levels  = out_r.line_levels;
  assign out_ch.busy_res     = out_r.busy_res;
  assign out_ch.accepted     = out_r.accepted;
  assign out_ch.rejected     = out_r.rejected;
  assign out_ch.cancel_total = out_r.cancel_total;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry holds a word while the output register is empty");

  a_idle_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> (phase_r == '0) && (bit_r == '0))
    else $error("bit timing counters left nonzero while idle");

  a_send_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && acc) |=> (ticks_r == '0) && sending_r)
    else $error("accepted send did not restart the frame");

  a_acc_rej_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_r.accepted && out_r.rejected))
    else $error("result word marked both accepted and rejected");

endmodule

`default_nettype wire

### tb/sv/tb_dshot_four_channel_transmitter.sv
`timescale 1ns / 1ps

module tb_dshot_four_channel_transmitter;
  import dsh4_pkg::*;

  localparam int LIVE_CH = (CHANNELS_DEFAULT < MAX_CHANNELS) ? CHANNELS_DEFAULT : MAX_CHANNELS;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    opcode_t          op;
    logic [THR_W-1:0] thr_a;
    logic [THR_W-1:0] thr_b;
    logic [THR_W-1:0] thr_c;
    logic [THR_W-1:0] thr_d;
  } dshot_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dsh4_in_if  in_if ();
  dsh4_out_if out_if ();

  dshot_four_channel_transmitter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  // Predicted block state and register copies.
  logic [INTERVAL_W-1:0] cfg_min_gap = MIN_INTERVAL_RST;
  logic [TICK_W-1:0]     cfg_period  = BIT_PERIOD_RST;
  logic [TICK_W-1:0]     cfg_zero_hi = ZERO_HIGH_RST;
  logic [TICK_W-1:0]     cfg_one_hi  = ONE_HIGH_RST;

  logic [15:0]           tick_age = '0;
  logic [15:0]           frame_sr [4] = '{default: '0};
  logic [4:0]            bit_pos = '0;
  logic [TICK_W-1:0]     phase_cnt = '0;
  logic                  xmit_on = 1'b0;
  logic [CANCEL_W-1:0]   cancel_cnt = '0;

  dshot_word_t pend_q [$];
  out_word_t   exp_q [$];
  int          words_open = 0;
  int          err_cnt = 0;
  int          cyc = 0;
  int          quiet = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          in_took = 1'b0;
  bit          out_took = 1'b0;

  wire calm = (cyc >= 1000) && (cyc < 1600);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] make_frame(logic [THR_W-1:0] thr);
    logic [15:0] data;
    logic [3:0]  sum;
    data = 16'(thr) << TELEM_SHIFT;
    sum  = data[7:4] ^ data[11:8] ^ data[15:12];
    return data | 16'(sum);
  endfunction

  function automatic logic [LEVELS_W-1:0] line_pattern();
    logic [LEVELS_W-1:0] lv;
    logic [TICK_W-1:0]   hi;
    lv = '0;
    if (xmit_on && bit_pos < FRAME_BITS) begin
      for (int n = 0; n < LIVE_CH; n++) begin
        hi = frame_sr[n][15 - bit_pos] ? cfg_one_hi : cfg_zero_hi;
        if (phase_cnt < hi) lv[n] = 1'b1;
      end
    end
    return lv;
  endfunction

  function automatic out_word_t predict_word(dshot_word_t w);
    out_word_t r;
    r = '0;
    if (w.op == OP_TICK) begin
      r.line_levels = line_pattern();
      r.busy_res = xmit_on;
      if (tick_age != 16'hFFFF) tick_age = tick_age + 1'b1;
      if (xmit_on) begin
        if (int'(phase_cnt) + 1 >= int'(cfg_period)) begin
          phase_cnt = '0;
          bit_pos = bit_pos + 1'b1;
          if (bit_pos >= FRAME_BITS) begin
            xmit_on = 1'b0;
            bit_pos = '0;
          end
        end else begin
          phase_cnt = phase_cnt + 1'b1;
        end
      end
    end else begin
      if (tick_age < cfg_min_gap) begin
        r.rejected = 1'b1;
        if (cancel_cnt != '1) cancel_cnt = cancel_cnt + 1'b1;
      end else begin
        r.accepted = 1'b1;
        tick_age = '0;
        frame_sr[0] = make_frame(w.thr_a);
        frame_sr[1] = make_frame(w.thr_b);
        frame_sr[2] = make_frame(w.thr_c);
        frame_sr[3] = make_frame(w.thr_d);
        bit_pos = '0;
        phase_cnt = '0;
        xmit_on = 1'b1;
      end
      r.line_levels = line_pattern();
      r.busy_res = xmit_on;
    end
    r.cancel_total = cancel_cnt;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  // Result check and prediction, both on the rising edge.
  always @(posedge clk) begin
    out_word_t exp_w;
    dshot_word_t w;
    cyc = cyc + 1;
    in_took = rst_n && in_if.valid && in_if.ready;
    out_took = rst_n && out_if.valid && out_if.ready;
    if (out_took) begin
      words_open--;
      if (exp_q.size() == 0) begin
        $error("result word with no expected word waiting");
        err_cnt++;
      end else begin
        exp_w = exp_q.pop_front();
        check_field("line_levels", 32'(exp_w.line_levels), 32'(out_if.line_levels));
        check_field("busy_res", 32'(exp_w.busy_res), 32'(out_if.busy_res));
        check_field("accepted", 32'(exp_w.accepted), 32'(out_if.accepted));
        check_field("rejected", 32'(exp_w.rejected), 32'(out_if.rejected));
        check_field("cancel_total", exp_w.cancel_total, out_if.cancel_total);
      end
    end
    if (in_took) begin
      w.op    = opcode_t'(in_if.opcode);
      w.thr_a = in_if.throttle_a;
      w.thr_b = in_if.throttle_b;
      w.thr_c = in_if.throttle_c;
      w.thr_d = in_if.throttle_d;
      exp_q.push_back(predict_word(w));
    end
    if (in_took || out_took) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Input driver: holds a word until it is taken, idles now and then between words.
  always @(negedge clk) begin
    dshot_word_t nxt;
    if (rst_n && !(in_if.valid && !in_took)) begin
      if (pend_q.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
        nxt = pend_q.pop_front();
        in_if.valid      <= 1'b1;
        in_if.opcode     <= nxt.op;
        in_if.throttle_a <= nxt.thr_a;
        in_if.throttle_b <= nxt.thr_b;
        in_if.throttle_c <= nxt.thr_c;
        in_if.throttle_d <= nxt.thr_d;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls and one long hold-off while words are still queued.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (rst_n && !hold_done && pend_q.size() > 100) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_n && (calm || $urandom_range(99) >= 9);
    end
  end

  task automatic queue_word(opcode_t op, logic [THR_W-1:0] a, logic [THR_W-1:0] b,
                            logic [THR_W-1:0] c, logic [THR_W-1:0] d);
    pend_q.push_back('{op: op, thr_a: a, thr_b: b, thr_c: c, thr_d: d});
    words_open++;
  endtask

  task automatic queue_rand(opcode_t op);
    queue_word(op, THR_W'($urandom), THR_W'($urandom), THR_W'($urandom), THR_W'($urandom));
  endtask

  // Mostly a send followed by close to enough ticks to finish its frames, the rest short noise.
  task automatic queue_traffic(int target, int per);
    int n;
    int len;
    n = 0;
    while (n < target) begin
      if ($urandom_range(9) < 7) begin
        queue_rand(OP_SEND);
        len = 16 * per - 3 + $urandom_range(0, 8);
        repeat (len) queue_rand(OP_TICK);
        n += len + 1;
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) queue_rand($urandom_range(1) ? OP_SEND : OP_TICK);
        n += len;
      end
    end
  endtask

  task automatic drain();
    while (words_open != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] gap, logic [7:0] per, logic [7:0] zh, logic [7:0] oh);
    cfg_idx_t    r;
    logic [15:0] vals [4];
    vals = '{gap, {8'd0, per}, {8'd0, zh}, {8'd0, oh}};
    r = r.first();
    repeat (4) begin
      cfg_we   = 1'b1;
      cfg_idx  = r;
      cfg_data = vals[int'(r)];
      case (r)
        CFG_MIN_INTERVAL: cfg_min_gap = vals[int'(r)];
        CFG_BIT_PERIOD:   cfg_period  = vals[int'(r)][7:0];
        CFG_ZERO_HIGH:    cfg_zero_hi = vals[int'(r)][7:0];
        CFG_ONE_HIGH:     cfg_one_hi  = vals[int'(r)][7:0];
        default: ;
      endcase
      @(negedge clk);
      r = r.next();
    end
    cfg_we = 1'b0;
  endtask

  initial begin
    int per;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_MIN_INTERVAL;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_TICK;
    in_if.throttle_a = '0;
    in_if.throttle_b = '0;
    in_if.throttle_c = '0;
    in_if.throttle_d = '0;
    out_if.ready     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Sends right after reset fall inside the rate limit and are cancelled.
    queue_word(OP_SEND, '1, '1, '1, '1);
    queue_word(OP_TICK, '0, '0, '0, '0);
    queue_word(OP_SEND, '0, '0, '0, '0);
    drain();

    // A zero interval accepts every send, so a send mid-frame restarts the frames.
    set_config(16'd0, 8'd4, 8'd1, 8'd254);
    queue_word(OP_SEND, 11'd2047, 11'd0, 11'd1365, 11'd682);
    repeat (6) queue_word(OP_TICK, '1, '1, '1, '1);
    queue_word(OP_SEND, 11'd0, 11'd2047, 11'd682, 11'd1365);
    repeat (3) queue_word(OP_TICK, '0, '0, '0, '0);
    queue_word(OP_SEND, 11'd1, 11'd1024, 11'd2046, 11'd3);
    repeat (2) queue_word(OP_TICK, '0, '0, '0, '0);
    drain();
    set_config(16'd5, 8'd2, 8'd254, 8'd1);
    queue_word(OP_SEND, 11'd85, 11'd170, 11'd1023, 11'd1536);
    repeat (4) queue_word(OP_TICK, '0, '0, '0, '0);
    queue_word(OP_SEND, 11'd2047, 11'd2047, 11'd0, 11'd0);
    drain();

    set_config(16'd0, 8'd2, 8'd1, 8'd1);
    queue_traffic(250, 2);
    drain();
    set_config(16'd4, 8'd2, 8'd1, 8'd254);
    queue_traffic(250, 2);
    drain();
    set_config(16'd12, 8'd7, 8'd3, 8'd5);
    queue_traffic(250, 7);
    drain();
    set_config(16'd2, 8'd255, 8'd254, 8'd1);
    queue_traffic(250, 20);
    drain();

    // A long interval cancels sends until enough ticks have gone by.
    set_config(16'd300, 8'd3, 8'd2, 8'd1);
    repeat (4) begin
      queue_rand(OP_SEND);
      repeat ($urandom_range(1, 20)) queue_rand(OP_TICK);
    end
    repeat (310) queue_rand(OP_TICK);
    queue_rand(OP_SEND);
    repeat (60) queue_rand(OP_TICK);
    queue_rand(OP_SEND);
    repeat (10) queue_rand(OP_TICK);
    drain();

    repeat (3) begin
      per = $urandom_range(2, 12);
      set_config(16'($urandom_range(0, 40)), 8'(per), 8'($urandom_range(1, per + 2)),
                 8'($urandom_range(1, per + 2)));
      queue_traffic(150, per);
      drain();
    end

    repeat (5) @(posedge clk);
    if (exp_q.size() != 0) begin
      $error("%0d expected words never arrived", exp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### dshot_four_channel_transmitter.f
design/dsh4_pkg.sv
design/dsh4_if.sv
design/dshot_four_channel_transmitter.sv
tb/sv/tb_dshot_four_channel_transmitter.sv
